// ----- design/afc_pkg.sv -----
// Shared types, widths, codes and the control store of the animation frame clock.
// Used by animation_frame_clock; depends on nothing else.
`timescale 1ns / 1ps

package afc_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int MODE_W     = 2;
	localparam int SPEED_W    = 24;
	localparam int FRAME_W    = 32;
	localparam int SCALE_W    = 24;
	localparam int ACT_W      = 2;
	localparam int RATE_W     = 24;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MUL_W  = 24;
	localparam int PROD_W = 3 * MUL_W;
	localparam int SPAN_W = FRAME_W + 2;
	localparam int PC_W   = 4;

	localparam logic [MODE_W-1:0] MODE_LOOP    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ONCE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PARTIAL = 2'd2;

	localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEEK    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NOP     = 2'd3;

	localparam logic [CFG_ADDR_W-1:0] CFG_MODE  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPEED = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_START = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_END   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_SCALE = 3'd4;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SIMPLE,
		OP_MUL_A,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_ACC,
		OP_NEXT,
		OP_DSET,
		OP_DSTEP,
		OP_WRAP,
		OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NEVER,
		C_NO_BEAT,
		C_SIMPLE,
		C_SEEK,
		C_ONCE,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	localparam logic [PC_W-1:0] P_WAIT  = 4'd0;
	localparam logic [PC_W-1:0] P_DSET  = 4'd8;
	localparam logic [PC_W-1:0] P_DSTEP = 4'd9;
	localparam logic [PC_W-1:0] P_FIN   = 4'd11;

	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t cw;
		unique case (pc)
			4'd0:    cw = '{OP_LOAD,   C_NO_BEAT,  P_WAIT};
			4'd1:    cw = '{OP_SIMPLE, C_SIMPLE,   P_FIN};
			4'd2:    cw = '{OP_NONE,   C_SEEK,     P_DSET};
			4'd3:    cw = '{OP_MUL_A,  C_NEVER,    P_WAIT};
			4'd4:    cw = '{OP_MUL_LO, C_NEVER,    P_WAIT};
			4'd5:    cw = '{OP_MUL_HI, C_NEVER,    P_WAIT};
			4'd6:    cw = '{OP_ACC,    C_NEVER,    P_WAIT};
			4'd7:    cw = '{OP_NEXT,   C_ONCE,     P_FIN};
			4'd8:    cw = '{OP_DSET,   C_NEVER,    P_WAIT};
			4'd9:    cw = '{OP_DSTEP,  C_DIV_MORE, P_DSTEP};
			4'd10:   cw = '{OP_WRAP,   C_NEVER,    P_WAIT};
			4'd11:   cw = '{OP_FINISH, C_OUT_BUSY, P_FIN};
			default: cw = '{OP_NONE,   C_ALWAYS,   P_WAIT};
		endcase
		return cw;
	endfunction

endpackage

// ----- design/animation_frame_clock.sv -----
// Animation frame clock: fixed-point frame accumulator run by a microcoded sequencer.
// Depends on afc_pkg (widths, codes, control store).
// Usage:
//   Input channel (in_valid/in_ready) takes one beat: action, rate, seek_frame.
//   Output channel (out_valid/out_ready) returns one beat per input: frame,
//   complete, finished_now, range_error. Configuration is written through
//   cfg_we/cfg_addr/cfg_wdata; the user must write it only while the block is idle,
//   and the block itself does not enforce this. Restart, no-op, range error,
//   once-mode seek, degenerate partial loops and advances at the end of a once play
//   finish from the simple step; other once-mode advances go through the multiply
//   steps, a wrapping advance runs the remainder loop after them, and a wrapping seek
//   goes straight to that loop. It runs D = max(72 - 2*FRAC_BITS, 32) + 2 restoring
//   steps (42 at FRAC_BITS = 16) and sets the throughput: a new beat is taken only
//   after the last one is finished. The advance product runs as three passes through one shared 24x24 multiplier.
//   Reset clears the frame and completion flag and loads the register defaults.
//   If the receiver stalls, the result holds in the output register; the next
//   beat is still taken and worked on, and its result waits until the output
//   register is free.
`timescale 1ns / 1ps

module animation_frame_clock #(
	parameter int FRAC_BITS = afc_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [afc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [afc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [afc_pkg::ACT_W-1:0]         action,
	input  logic [afc_pkg::RATE_W-1:0]        rate,
	input  logic signed [afc_pkg::FRAME_W-1:0] seek_frame,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [afc_pkg::FRAME_W-1:0] frame,
	output logic                              complete,
	output logic                              finished_now,
	output logic                              range_error
);
	import afc_pkg::*;

	localparam int MAG_W  = PROD_W - 2 * FRAC_BITS;
	localparam int BASE_W = (MAG_W > FRAME_W) ? MAG_W : FRAME_W;
	localparam int WIDE_W = BASE_W + 3;
	localparam int DVD_W  = WIDE_W - 1;
	localparam int CNT_W  = $clog2(WIDE_W);
	localparam int SUM_W  = SPAN_W + 1;

	// configuration
	logic [MODE_W-1:0]         mode_q;
	logic [SPEED_W-1:0]        speed_q;
	logic signed [FRAME_W-1:0] start_q;
	logic signed [FRAME_W-1:0] end_q;
	logic [SCALE_W-1:0]        scale_q;

	// state
	logic signed [FRAME_W-1:0] cur_q;
	logic                      done_q;

	// sequencer
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ctrl_word_t      cw;
	logic            cond_hit;

	// datapath
	logic [ACT_W-1:0]          act_q;
	logic [RATE_W-1:0]         rate_q;
	logic signed [FRAME_W-1:0] seek_q;
	logic [2*MUL_W-1:0]        prod_q;
	logic [MUL_W-1:0]          m1_hi_q;
	logic [PROD_W-1:0]         acc_q;
	logic signed [WIDE_W-1:0]  next_q;
	logic [DVD_W-1:0]          dvd_q;
	logic [SPAN_W-2:0]         rem_q;
	logic                      neg_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [FRAME_W-1:0] res_frame_q;
	logic                      res_done_q;
	logic                      res_fin_q;
	logic                      res_err_q;
	logic                      out_valid_q;

	logic                      in_fire;
	logic                      out_busy;
	logic                      fin_write;
	logic                      once;
	logic                      partial;
	logic                      err;
	logic                      span_zero;
	logic                      is_simple;
	logic signed [FRAME_W-1:0] simp_frame;
	logic                      simp_done;
	logic                      simp_fin;
	logic signed [FRAME_W-1:0] lo_b;
	logic signed [FRAME_W-1:0] hi_b;
	logic [SPEED_W-1:0]        spd_mag;
	logic                      spd_neg;
	logic                      spd_pos;
	logic [MUL_W-1:0]          mul_a;
	logic [MUL_W-1:0]          mul_b;
	logic [2*MUL_W-1:0]        mul_p;
	logic [MAG_W-1:0]          mag;
	logic signed [WIDE_W-1:0]  cur_w;
	logic signed [WIDE_W-1:0]  end_w;
	logic signed [WIDE_W-1:0]  start_w;
	logic signed [WIDE_W-1:0]  seek_w;
	logic signed [WIDE_W-1:0]  next_w;
	logic signed [FRAME_W-1:0] once_frame;
	logic signed [WIDE_W-1:0]  d_w;
	logic [WIDE_W-1:0]         d_mag;
	logic [SPAN_W-1:0]         diff;
	logic [SPAN_W-1:0]         span;
	logic [SPAN_W-1:0]         sh;
	logic [SPAN_W-1:0]         r_fix;
	logic [SUM_W-1:0]          sum;
	logic signed [FRAME_W-1:0] wrap_frame;

	assign in_ready = (pc_q == P_WAIT);
	assign in_fire  = in_valid && in_ready;
	assign out_busy = out_valid_q && !out_ready;

	assign once      = (mode_q == MODE_ONCE);
	assign partial   = (mode_q == MODE_PARTIAL);
	assign err       = !once && (end_q < start_q);
	assign span_zero = partial && (end_q == start_q);

	assign spd_neg = speed_q[SPEED_W-1];
	assign spd_pos = !spd_neg && (speed_q != '0);
	assign spd_mag = spd_neg ? (~speed_q + 1'b1) : speed_q;

	assign lo_b = (start_q < end_q) ? start_q : end_q;
	assign hi_b = (start_q < end_q) ? end_q : start_q;

	// single-step actions and the flags every action carries
	always_comb begin
		is_simple  = 1'b0;
		simp_frame = cur_q;
		simp_done  = done_q;
		simp_fin   = 1'b0;
		if (err || act_q == ACT_NOP) begin
			is_simple = 1'b1;
		end else if (act_q == ACT_RESTART) begin
			is_simple  = 1'b1;
			simp_frame = partial ? '0 : start_q;
			simp_done  = 1'b0;
		end else if (act_q == ACT_SEEK) begin
			simp_done = 1'b0;
			if (once) begin
				is_simple  = 1'b1;
				simp_frame = (seek_q < lo_b) ? lo_b : ((seek_q > hi_b) ? hi_b : seek_q);
			end else if (span_zero) begin
				is_simple  = 1'b1;
				simp_frame = start_q;
			end
		end else begin
			if (once && cur_q == end_q) begin
				is_simple = 1'b1;
				simp_done = 1'b1;
				simp_fin  = 1'b1;
			end else if (span_zero) begin
				is_simple  = 1'b1;
				simp_frame = start_q;
			end
		end
	end

	// shared multiplier
	always_comb begin
		mul_a = spd_mag;
		mul_b = rate_q;
		case (cw.op)
			OP_MUL_LO: begin
				mul_a = prod_q[MUL_W-1:0];
				mul_b = scale_q;
			end
			OP_MUL_HI: begin
				mul_a = m1_hi_q;
				mul_b = scale_q;
			end
			default: begin
				mul_a = spd_mag;
				mul_b = rate_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign mag     = acc_q[2*FRAC_BITS +: MAG_W];
	assign cur_w   = {{(WIDE_W-FRAME_W){cur_q[FRAME_W-1]}}, cur_q};
	assign end_w   = {{(WIDE_W-FRAME_W){end_q[FRAME_W-1]}}, end_q};
	assign start_w = {{(WIDE_W-FRAME_W){start_q[FRAME_W-1]}}, start_q};
	assign seek_w  = {{(WIDE_W-FRAME_W){seek_q[FRAME_W-1]}}, seek_q};
	assign next_w  = spd_neg ? (cur_w - $signed({{(WIDE_W-MAG_W){1'b0}}, mag}))
	                         : (cur_w + $signed({{(WIDE_W-MAG_W){1'b0}}, mag}));

	always_comb begin
		if ((spd_pos && next_w > end_w) || (spd_neg && next_w < end_w)) begin
			once_frame = end_q;
		end else begin
			once_frame = next_w[FRAME_W-1:0];
		end
	end

	// wrap span and remainder step
	assign diff = {{(SPAN_W-FRAME_W){end_q[FRAME_W-1]}}, end_q}
	            - {{(SPAN_W-FRAME_W){start_q[FRAME_W-1]}}, start_q};
	assign span = partial ? diff : (diff + (SPAN_W'(1) << FRAC_BITS));

	assign d_w   = ((act_q == ACT_SEEK) ? seek_w : next_q) - start_w;
	assign d_mag = d_w[WIDE_W-1] ? (~d_w + 1'b1) : d_w;

	assign sh = {rem_q, dvd_q[DVD_W-1]};

	assign r_fix = (neg_q && rem_q != '0) ? (span - {1'b0, rem_q}) : {1'b0, rem_q};
	assign sum   = {{(SUM_W-FRAME_W){start_q[FRAME_W-1]}}, start_q} + {1'b0, r_fix};

	always_comb begin
		if (!sum[SUM_W-1] && sum[SUM_W-2:FRAME_W-1] != '0) begin
			wrap_frame = {1'b0, {(FRAME_W-1){1'b1}}};
		end else begin
			wrap_frame = sum[FRAME_W-1:0];
		end
	end

	// sequencer
	assign cw = ucode(pc_q);

	always_comb begin
		unique case (cw.cond)
			C_ALWAYS:   cond_hit = 1'b1;
			C_NEVER:    cond_hit = 1'b0;
			C_NO_BEAT:  cond_hit = !in_fire;
			C_SIMPLE:   cond_hit = is_simple;
			C_SEEK:     cond_hit = (act_q == ACT_SEEK);
			C_ONCE:     cond_hit = once;
			C_DIV_MORE: cond_hit = (cnt_q != CNT_W'(1));
			C_OUT_BUSY: cond_hit = out_busy;
			default:    cond_hit = 1'b1;
		endcase
	end

	assign pc_next   = cond_hit ? cw.target : (pc_q + 1'b1);
	assign fin_write = (cw.op == OP_FINISH) && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LOOP;
			speed_q <= SPEED_W'(1) << FRAC_BITS;
			start_q <= '0;
			end_q   <= '0;
			scale_q <= SCALE_W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MODE:  mode_q  <= cfg_wdata[MODE_W-1:0];
				CFG_SPEED: speed_q <= cfg_wdata[SPEED_W-1:0];
				CFG_START: start_q <= cfg_wdata[FRAME_W-1:0];
				CFG_END:   end_q   <= cfg_wdata[FRAME_W-1:0];
				CFG_SCALE: scale_q <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_write) begin
				cur_q       <= res_frame_q;
				done_q      <= res_done_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_LOAD: begin
				if (in_fire) begin
					act_q  <= action;
					rate_q <= rate;
					seek_q <= seek_frame;
				end
			end
			OP_SIMPLE: begin
				res_frame_q <= simp_frame;
				res_done_q  <= simp_done;
				res_fin_q   <= simp_fin;
				res_err_q   <= err;
			end
			OP_MUL_A: prod_q <= mul_p;
			OP_MUL_LO: begin
				m1_hi_q <= prod_q[2*MUL_W-1:MUL_W];
				prod_q  <= mul_p;
			end
			OP_MUL_HI: begin
				acc_q  <= PROD_W'(prod_q);
				prod_q <= mul_p;
			end
			OP_ACC: acc_q <= acc_q + (PROD_W'(prod_q) << MUL_W);
			OP_NEXT: begin
				next_q      <= next_w;
				res_frame_q <= once_frame;
			end
			OP_DSET: begin
				neg_q <= d_w[WIDE_W-1];
				dvd_q <= d_mag[DVD_W-1:0];
				rem_q <= '0;
				cnt_q <= CNT_W'(DVD_W);
			end
			OP_DSTEP: begin
				if (sh >= span) begin
					rem_q <= (SPAN_W-1)'(sh - span);
				end else begin
					rem_q <= sh[SPAN_W-2:0];
				end
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			OP_WRAP: res_frame_q <= wrap_frame;
			OP_FINISH: begin
				if (!out_busy) begin
					frame        <= res_frame_q;
					complete     <= res_done_q;
					finished_now <= res_fin_q;
					range_error  <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pc_q == P_FIN))
		else $error("result raised outside the finish step");

	a_finish_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && finished_now) |-> (complete && !range_error))
		else $error("finished beat without completion or with range error");

	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == P_DSTEP) |-> ({1'b0, rem_q} < span))
		else $error("partial remainder not reduced below span");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while one is in work");

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for animation_frame_clock: directed rows, then random beats with gaps on both sides,
// each result compared against a bit-exact in-bench predictor of the frame clock or a row's fixed result.
// Depends on afc_pkg and animation_frame_clock.
`timescale 1ns / 1ps

module tb;
	import afc_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [31:0] ONE = 32'd1 << FRAC;
	localparam longint FRAME_MAX = 64'sh7FFF_FFFF;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int SETTLE = 8;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               complete;
		logic               finished_now;
		logic               range_error;
	} frame_result_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_ADDR_W-1:0] reg_idx;
		logic [CFG_DATA_W-1:0] value;
		logic [ACT_W-1:0]      act;
		logic [RATE_W-1:0]     rate;
		logic [FRAME_W-1:0]    seek;
		bit                    typed;
		frame_result_t         want;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
	logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [ACT_W-1:0]         action = ACT_NOP;
	logic [RATE_W-1:0]        rate = '0;
	logic signed [FRAME_W-1:0] seek_frame = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [FRAME_W-1:0] frame;
	logic                     complete;
	logic                     finished_now;
	logic                     range_error;

	// register shadow and frame state of the predictor
	logic [MODE_W-1:0]          cfg_mode = MODE_LOOP;
	logic signed [SPEED_W-1:0]  cfg_speed = SPEED_W'(ONE);
	logic signed [FRAME_W-1:0]  cfg_start = '0;
	logic signed [FRAME_W-1:0]  cfg_end = '0;
	logic [SCALE_W-1:0]         cfg_scale = SCALE_W'(ONE);
	logic signed [FRAME_W-1:0]  cur_frame = '0;
	logic                       play_done = 1'b0;

	frame_result_t expected_q[$];
	stim_row_t     dir_rows[$];
	int            errors = 0;
	int            beats_sent = 0;
	int            results_seen = 0;
	int            reg_writes = 0;
	bit            quiet = 1'b0;
	int            rx_hold_req = 0;

	animation_frame_clock u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.rate         (rate),
		.seek_frame   (seek_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame        (frame),
		.complete     (complete),
		.finished_now (finished_now),
		.range_error  (range_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint wrap_into_range(longint f, longint lo, longint hi);
		longint span;
		longint r;
		if (cfg_mode == MODE_PARTIAL)
			span = hi - lo;
		else
			span = hi - lo + (longint'(1) << FRAC);
		if (span <= 0)
			return lo;
		r = (f - lo) % span;
		if (r < 0)
			r += span;
		r = lo + r;
		return r > FRAME_MAX ? FRAME_MAX : r;
	endfunction

	function automatic frame_result_t step_frame_clock(logic [ACT_W-1:0] a, logic [RATE_W-1:0] r,
			logic signed [FRAME_W-1:0] s);
		frame_result_t res;
		longint spd, st, en, sk, cur, nxt, mag, lo, hi;
		logic [23:0] spd_mag;
		logic [71:0] prod;
		bit once, err, fin;
		spd = cfg_speed;
		st = cfg_start;
		en = cfg_end;
		sk = s;
		cur = cur_frame;
		once = cfg_mode == MODE_ONCE;
		err = !once && en < st;
		fin = 1'b0;
		if (!err) begin
			case (a)
				ACT_ADVANCE: begin
					if (once && cur == en) begin
						play_done = 1'b1;
						fin = 1'b1;
					end else begin
						spd_mag = spd < 0 ? 24'(-spd) : 24'(spd);
						prod = {48'd0, spd_mag} * {48'd0, r} * {48'd0, cfg_scale};
						mag = longint'(prod >> (2 * FRAC));
						nxt = spd < 0 ? cur - mag : cur + mag;
						if (once)
							cur_frame = ((spd > 0 && nxt > en) || (spd < 0 && nxt < en)) ? en : nxt;
						else
							cur_frame = wrap_into_range(nxt, st, en);
					end
				end
				ACT_SEEK: begin
					if (once) begin
						lo = st < en ? st : en;
						hi = st < en ? en : st;
						cur_frame = sk < lo ? lo : (sk > hi ? hi : sk);
					end else begin
						cur_frame = wrap_into_range(sk, st, en);
					end
					play_done = 1'b0;
				end
				ACT_RESTART: begin
					cur_frame = cfg_mode == MODE_PARTIAL ? '0 : cfg_start;
					play_done = 1'b0;
				end
				default: ;
			endcase
		end
		res.frame = cur_frame;
		res.complete = play_done;
		res.finished_now = fin;
		res.range_error = err;
		return res;
	endfunction

	function automatic int gap_cycles();
		int u;
		u = $urandom_range(0, 99);
		if (quiet || u < 50)
			return 0;
		if (u < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.value = v;
		return row;
	endfunction

	function automatic stim_row_t beat_row(logic [ACT_W-1:0] a, logic [RATE_W-1:0] r,
			logic [FRAME_W-1:0] s);
		stim_row_t row;
		row = '{default: '0};
		row.act = a;
		row.rate = r;
		row.seek = s;
		return row;
	endfunction

	function automatic stim_row_t known_row(logic [ACT_W-1:0] a, logic [RATE_W-1:0] r,
			logic [FRAME_W-1:0] s, logic [FRAME_W-1:0] f, bit c, bit fin, bit err);
		stim_row_t row;
		row = beat_row(a, r, s);
		row.typed = 1'b1;
		row.want = '{f, c, fin, err};
		return row;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
		errors++;
		$display("result %0d: %s expected %h got %h", results_seen, what, want_v, got_v);
	endtask

	task automatic check_result();
		frame_result_t want;
		results_seen++;
		if (expected_q.size() == 0) begin
			flag_mismatch("beat with nothing pending, frame", 'x, frame);
		end else begin
			want = expected_q.pop_front();
			if (frame !== want.frame)
				flag_mismatch("frame", want.frame, frame);
			if (complete !== want.complete)
				flag_mismatch("complete", want.complete, complete);
			if (finished_now !== want.finished_now)
				flag_mismatch("finished_now", want.finished_now, finished_now);
			if (range_error !== want.range_error)
				flag_mismatch("range_error", want.range_error, range_error);
		end
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		reg_writes++;
		case (idx)
			CFG_MODE:  cfg_mode = v[MODE_W-1:0];
			CFG_SPEED: cfg_speed = v[SPEED_W-1:0];
			CFG_START: cfg_start = v;
			CFG_END:   cfg_end = v;
			CFG_SCALE: cfg_scale = v[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_beat(logic [ACT_W-1:0] a, logic [RATE_W-1:0] r, logic [FRAME_W-1:0] s,
			bit typed, frame_result_t want);
		int gap;
		frame_result_t calc;
		gap = gap_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		rate <= r;
		seek_frame <= s;
		do @(posedge clk); while (!in_ready);
		calc = step_frame_clock(a, r, s);
		expected_q.push_back(typed ? want : calc);
		beats_sent++;
	endtask

	task automatic send_random_beat();
		logic [ACT_W-1:0] a;
		logic [RATE_W-1:0] r;
		logic [FRAME_W-1:0] s;
		int u;
		u = $urandom_range(0, 19);
		a = u < 12 ? ACT_ADVANCE : (u < 16 ? ACT_SEEK : (u < 19 ? ACT_RESTART : ACT_NOP));
		case ($urandom_range(0, 5))
			0, 1, 2: r = RATE_W'($urandom_range(0, 2 * ONE));
			3:       r = RATE_W'($urandom_range(0, ONE / 16));
			4:       r = RATE_W'($urandom());
			default: r = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h0;
		endcase
		case ($urandom_range(0, 3))
			0, 1:    s = cfg_start + $urandom_range(0, 40 * ONE) - 4 * ONE;
			2:       s = $urandom();
			default: s = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
		send_beat(a, r, s, 1'b0, '0);
	endtask

	task automatic shuffle_regs();
		int u;
		logic [31:0] v;
		u = $urandom_range(0, 9);
		write_reg(CFG_MODE, CFG_DATA_W'(u < 3 ? MODE_LOOP :
			(u < 6 ? MODE_ONCE : (u < 9 ? MODE_PARTIAL : MODE_SPARE))));
		case ($urandom_range(0, 5))
			0:       v = ONE;
			1:       v = $urandom_range(0, 4 * ONE);
			2:       v = -$urandom_range(1, 4 * ONE);
			3:       v = $urandom();
			4:       v = $urandom_range(0, 1) ? 32'h0080_0000 : 32'h007F_FFFF;
			default: v = '0;
		endcase
		write_reg(CFG_SPEED, v);
		case ($urandom_range(0, 4))
			0, 1, 2: v = $urandom_range(0, 128 * ONE) - 64 * ONE;
			3:       v = $urandom();
			default: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_0000;
		endcase
		write_reg(CFG_START, v);
		case ($urandom_range(0, 5))
			0, 1, 2: v = v + $urandom_range(0, 32 * ONE);
			3:       v = v - $urandom_range(1, 8 * ONE);
			4:       v = $urandom();
			default: v = 32'h7FFF_FFFF;
		endcase
		write_reg(CFG_END, v);
		case ($urandom_range(0, 5))
			0, 1:    v = ONE;
			2:       v = $urandom_range(0, 2 * ONE);
			3:       v = $urandom();
			4:       v = 32'h00FF_FFFF;
			default: v = '0;
		endcase
		write_reg(CFG_SCALE, v);
		cfg_we <= 1'b0;
	endtask

	initial begin : result_sink
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_result();
			if (rx_hold_req > 0) begin
				hold = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = gap_cycles();
			end
		end
	end

	initial begin : stimulus
		bit cfg_open;
		int ph;
		cfg_open = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows.push_back(known_row(ACT_ADVANCE, 24'h01_0000, '0, '0, 0, 0, 0));
		dir_rows.push_back(known_row(ACT_RESTART, '0, '0, '0, 0, 0, 0));
		dir_rows.push_back(known_row(ACT_NOP, 24'hFF_FFFF, 32'hFFFF_FFFF, '0, 0, 0, 0));
		dir_rows.push_back(reg_row(CFG_END, 32'h000A_0000));
		dir_rows.push_back(beat_row(ACT_ADVANCE, 24'hFF_FFFF, '0));
		dir_rows.push_back(beat_row(ACT_SEEK, '0, 32'h7FFF_FFFF));
		dir_rows.push_back(beat_row(ACT_SEEK, '0, 32'h8000_0000));
		dir_rows.push_back(reg_row(CFG_END, 32'hFFFF_0000));
		dir_rows.push_back(beat_row(ACT_ADVANCE, 24'h01_0000, '0));
		dir_rows.push_back(beat_row(ACT_SEEK, '0, 32'h0003_0000));
		dir_rows.push_back(beat_row(ACT_RESTART, '0, '0));
		dir_rows.push_back(reg_row(CFG_MODE, CFG_DATA_W'(MODE_ONCE)));
		dir_rows.push_back(reg_row(CFG_END, 32'h000A_0000));
		dir_rows.push_back(known_row(ACT_RESTART, '0, '0, '0, 0, 0, 0));
		dir_rows.push_back(known_row(ACT_ADVANCE, 24'h05_0000, '0, 32'h0005_0000, 0, 0, 0));
		dir_rows.push_back(known_row(ACT_ADVANCE, 24'h10_0000, '0, 32'h000A_0000, 0, 0, 0));
		dir_rows.push_back(known_row(ACT_ADVANCE, '0, '0, 32'h000A_0000, 1, 1, 0));
		dir_rows.push_back(known_row(ACT_ADVANCE, 24'hFF_FFFF, '0, 32'h000A_0000, 1, 1, 0));
		dir_rows.push_back(known_row(ACT_SEEK, '0, 32'h7FFF_FFFF, 32'h000A_0000, 0, 0, 0));
		dir_rows.push_back(known_row(ACT_SEEK, '0, 32'h8000_0000, '0, 0, 0, 0));
		dir_rows.push_back(reg_row(CFG_SPEED, 32'h0080_0000));
		dir_rows.push_back(reg_row(CFG_END, 32'hFFFB_0000));
		dir_rows.push_back(known_row(ACT_ADVANCE, 24'h01_0000, '0, 32'hFFFB_0000, 0, 0, 0));
		dir_rows.push_back(known_row(ACT_ADVANCE, 24'h01_0000, '0, 32'hFFFB_0000, 1, 1, 0));
		dir_rows.push_back(reg_row(CFG_MODE, CFG_DATA_W'(MODE_PARTIAL)));
		dir_rows.push_back(reg_row(CFG_START, 32'h0001_0000));
		dir_rows.push_back(reg_row(CFG_END, 32'h0001_0000));
		dir_rows.push_back(known_row(ACT_SEEK, '0, 32'h1234_5678, 32'h0001_0000, 0, 0, 0));
		dir_rows.push_back(known_row(ACT_RESTART, '0, '0, '0, 0, 0, 0));
		dir_rows.push_back(known_row(ACT_ADVANCE, 24'h01_0000, '0, 32'h0001_0000, 0, 0, 0));
		dir_rows.push_back(reg_row(CFG_MODE, CFG_DATA_W'(MODE_SPARE)));
		dir_rows.push_back(reg_row(CFG_SPEED, 32'h007F_FFFF));
		dir_rows.push_back(reg_row(CFG_SCALE, 32'h00FF_FFFF));
		dir_rows.push_back(reg_row(CFG_START, 32'h8000_0000));
		dir_rows.push_back(reg_row(CFG_END, 32'h7FFF_FFFF));
		dir_rows.push_back(beat_row(ACT_ADVANCE, 24'hFF_FFFF, '0));
		dir_rows.push_back(known_row(ACT_SEEK, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
		dir_rows.push_back(beat_row(ACT_ADVANCE, 24'h01_0000, '0));
		dir_rows.push_back(reg_row(CFG_MODE, CFG_DATA_W'(MODE_ONCE)));
		dir_rows.push_back(reg_row(CFG_SPEED, '0));
		dir_rows.push_back(reg_row(CFG_SCALE, '0));
		dir_rows.push_back(beat_row(ACT_ADVANCE, 24'hFF_FFFF, '0));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				if (!cfg_open) begin
					wait_results_drained();
					cfg_open = 1'b1;
				end
				write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
			end else begin
				if (cfg_open) begin
					cfg_we <= 1'b0;
					cfg_open = 1'b0;
				end
				send_beat(dir_rows[i].act, dir_rows[i].rate, dir_rows[i].seek,
					dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// hold the result side off while beats stream in back to back
		wait_results_drained();
		shuffle_regs();
		quiet = 1'b1;
		rx_hold_req = 400;
		repeat (10) send_random_beat();
		quiet = 1'b0;

		for (ph = 0; ph < 8; ph++) begin
			wait_results_drained();
			shuffle_regs();
			quiet = ph % 3 == 2;
			repeat (52) send_random_beat();
		end
		quiet = 1'b0;
		wait_results_drained();
		repeat (60) @(posedge clk);

		$display("Sent %0d beats over %0d register writes, checked %0d results.",
			beats_sent, reg_writes, results_seen);
		$display("Covered loop, once, partial and spare modes, seeks, restarts and range errors.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/afc_pkg.sv
design/animation_frame_clock.sv
verif/tb.sv
